### design/sqt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_pkg
// Shared types and constants of the shell-style command line tokenizer.
// ----------------------------------------------------------------------------
package sqt_pkg;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Result queue
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PW    = 2;   // pointer width
  localparam int unsigned FIFO_CW    = 3;   // count width, holds FIFO_DEPTH

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_QUOTE  = 3'd1,
    ST_UNCLOSED   = 3'd2,
    ST_UNUSED_ESC = 3'd3,
    ST_TOO_LONG   = 3'd4,
    ST_TOO_MANY   = 3'd5
  } status_e;

  // Parser flags
  typedef struct packed {
    logic inside_token;
    logic inside_quote;
    logic quote_is_double;
    logic escape_pending;
    logic backslash_held;
  } flags_t;

  // One result item, out_char in the low bits
  typedef struct packed {
    logic          last;
    logic          line_done;
    status_e       status;
    logic [3:0]    token_number;
    logic          token_end;
    logic          has_char;
    logic [7:0]    out_char;
  } res_t;

endpackage

### design/sqt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_step
// Next-state and result logic for one character or end-of-line request.
// ----------------------------------------------------------------------------
module sqt_step #(
  parameter int unsigned MAX_TOKENS    = 16,
  parameter int unsigned MAX_TOKEN_LEN = 64,
  parameter int unsigned TW            = $clog2(MAX_TOKENS + 1),
  parameter int unsigned CW            = $clog2(MAX_TOKEN_LEN)
) (
  input  logic [7:0]      in_char_i,
  input  logic            eol_i,
  input  sqt_pkg::flags_t flags_i,
  input  logic [TW-1:0]   tokens_i,
  input  logic [CW-1:0]   chars_i,
  output sqt_pkg::flags_t flags_o,
  output logic [TW-1:0]   tokens_o,
  output logic [CW-1:0]   chars_o,
  output sqt_pkg::res_t   res0_o,
  output sqt_pkg::res_t   res1_o,
  output logic [1:0]      res_cnt_o
);

  localparam int unsigned TNW = (TW > 4) ? TW : 4;
  localparam logic [CW-1:0] LEN_LIM = CW'(MAX_TOKEN_LEN - 1);
  localparam logic [TW-1:0] TOK_LIM = TW'(MAX_TOKENS);

  function automatic sqt_pkg::res_t mk(input logic [7:0] ch, input logic has,
                                       input logic tend, input sqt_pkg::status_e st,
                                       input logic done, input logic [3:0] tn);
    sqt_pkg::res_t r;
    r.out_char     = ch;
    r.has_char     = has;
    r.token_end    = tend;
    r.token_number = tn;
    r.status       = st;
    r.line_done    = done;
    r.last         = 1'b0;
    return r;
  endfunction

  logic [TNW-1:0] tok_ext;
  logic [3:0]     tn;

  assign tok_ext = TNW'(tokens_i);
  assign tn      = tok_ext[3:0];

  always_comb begin
    sqt_pkg::flags_t f;
    sqt_pkg::res_t   res [2];
    logic [TW-1:0]   nt;
    logic [CW-1:0]   nn;
    logic [1:0]      cnt;
    logic            is_ws;
    logic            is_quote;
    logic            held_match;
    logic            do_add;
    logic            do_finish;
    logic            do_bad;

    f          = flags_i;
    nt         = tokens_i;
    nn         = chars_i;
    cnt        = 2'd0;
    res[0]     = '0;
    res[1]     = '0;
    do_add     = 1'b0;
    do_finish  = 1'b0;
    do_bad     = 1'b0;
    is_ws      = (in_char_i == sqt_pkg::CH_SPACE) || (in_char_i == sqt_pkg::CH_TAB) ||
                 (in_char_i == sqt_pkg::CH_NL);
    is_quote   = (in_char_i == sqt_pkg::CH_SQUOTE) || (in_char_i == sqt_pkg::CH_DQUOTE);
    held_match = ((in_char_i == sqt_pkg::CH_DQUOTE) && flags_i.quote_is_double) ||
                 ((in_char_i == sqt_pkg::CH_SQUOTE) && !flags_i.quote_is_double);

    if (eol_i) begin
      if (f.backslash_held) begin
        if (nn < LEN_LIM) begin
          res[cnt[0]] = mk(sqt_pkg::CH_BSLASH, 1'b1, 1'b0, sqt_pkg::ST_OK, 1'b0, tn);
        end else begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_TOO_LONG, 1'b0, tn);
        end
        cnt = cnt + 2'd1;
      end else if (f.escape_pending) begin
        res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_UNUSED_ESC, 1'b0, tn);
        cnt = cnt + 2'd1;
      end
      if (f.inside_quote) begin
        res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_UNCLOSED, 1'b1, tn);
      end else if (f.inside_token) begin
        if (nt < TOK_LIM) begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b1, sqt_pkg::ST_OK, 1'b1, tn);
        end else begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_TOO_MANY, 1'b1, tn);
        end
      end else begin
        res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_OK, 1'b1, tn);
      end
      cnt = cnt + 2'd1;
      // line flushed
      f  = '0;
      nt = '0;
      nn = '0;
    end else begin
      // held backslash inside quotes: literal quote or literal backslash
      if (f.backslash_held) begin
        f.backslash_held = 1'b0;
        if (nn < LEN_LIM) begin
          res[cnt[0]] = mk(held_match ? in_char_i : sqt_pkg::CH_BSLASH, 1'b1, 1'b0,
                           sqt_pkg::ST_OK, 1'b0, tn);
          nn = nn + 1'b1;
        end else begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_TOO_LONG, 1'b0, tn);
        end
        cnt = cnt + 2'd1;
      end

      if (!(flags_i.backslash_held && held_match)) begin
        if (f.escape_pending) begin
          f.escape_pending = 1'b0;
          f.inside_token   = 1'b1;
          do_add           = 1'b1;
        end else if (is_ws) begin
          if (f.inside_token) begin
            if (f.inside_quote) do_add = 1'b1;
            else                do_finish = 1'b1;
          end
        end else if (is_quote) begin
          if (!f.inside_token) begin
            f.inside_token    = 1'b1;
            f.inside_quote    = 1'b1;
            f.quote_is_double = (in_char_i == sqt_pkg::CH_DQUOTE);
          end else if (f.inside_quote) begin
            if ((in_char_i == sqt_pkg::CH_DQUOTE) == f.quote_is_double) begin
              f.inside_quote = 1'b0;
              do_finish      = 1'b1;
            end else begin
              do_add = 1'b1;
            end
          end else begin
            do_bad = 1'b1;
          end
        end else if (in_char_i == sqt_pkg::CH_BSLASH) begin
          if (f.inside_quote) f.backslash_held = 1'b1;
          else                f.escape_pending = 1'b1;
        end else begin
          f.inside_token = 1'b1;
          do_add         = 1'b1;
        end
      end

      if (do_add) begin
        if (nn < LEN_LIM) begin
          res[cnt[0]] = mk(in_char_i, 1'b1, 1'b0, sqt_pkg::ST_OK, 1'b0, tn);
          nn = nn + 1'b1;
        end else begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_TOO_LONG, 1'b0, tn);
        end
        cnt = cnt + 2'd1;
      end else if (do_finish) begin
        if (nt < TOK_LIM) begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b1, sqt_pkg::ST_OK, 1'b0, tn);
          nt = nt + 1'b1;
        end else begin
          res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_TOO_MANY, 1'b0, tn);
        end
        cnt            = cnt + 2'd1;
        f.inside_token = 1'b0;
        nn             = '0;
      end else if (do_bad) begin
        res[cnt[0]] = mk(8'h00, 1'b0, 1'b0, sqt_pkg::ST_BAD_QUOTE, 1'b0, tn);
        cnt = cnt + 2'd1;
      end
    end

    res[0].last = (cnt == 2'd1);
    res[1].last = (cnt == 2'd2);

    flags_o   = f;
    tokens_o  = nt;
    chars_o   = nn;
    res0_o    = res[0];
    res1_o    = res[1];
    res_cnt_o = cnt;
  end

endmodule

### design/sqt_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqt_res_fifo
// Result queue: up to two writes per cycle, one read per cycle.
// ----------------------------------------------------------------------------
module sqt_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [1:0]                    push_cnt_i,
  input  sqt_pkg::res_t                 push0_i,
  input  sqt_pkg::res_t                 push1_i,
  output logic                          room2_o,
  output logic                          valid_o,
  input  logic                          pop_i,
  output sqt_pkg::res_t                 data_o,
  output logic [sqt_pkg::FIFO_CW-1:0]   count_o
);

  sqt_pkg::res_t                 mem [sqt_pkg::FIFO_DEPTH];
  logic [sqt_pkg::FIFO_PW-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sqt_pkg::FIFO_CW-1:0]   count_q, count_d;
  logic                          do_pop;

  assign valid_o = (count_q != '0);
  assign room2_o = (count_q <= sqt_pkg::FIFO_CW'(sqt_pkg::FIFO_DEPTH - 2));
  assign do_pop  = pop_i && valid_o;
  assign data_o  = mem[rptr_q];
  assign count_o = count_q;

  always_comb begin
    wptr_d  = wptr_q + sqt_pkg::FIFO_PW'(push_cnt_i);
    rptr_d  = rptr_q + sqt_pkg::FIFO_PW'(do_pop);
    count_d = count_q + sqt_pkg::FIFO_CW'(push_cnt_i) - sqt_pkg::FIFO_CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem[wptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem[wptr_q + 1'b1] <= push1_i;
    end
  end

endmodule

### design/shell_quote_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shell_quote_tokenizer_top
// Shell-style command line tokenizer: splits a byte stream into tokens.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one command line byte per request in s_axis_tdata;
//   s_axis_tlast high marks an end-of-line request (data byte ignored), which
//   closes any open token and returns the parser to its idle state.
//   Master stream carries result items: token characters, token-end marks,
//   error codes and the line-done mark. m_axis_tlast flags the last result
//   caused by one input request; a request may cause no result at all.
// Results: the results of an accepted request are registered in the result
//   queue and leave it from its head in order.
// Throughput: one request per cycle while each request gives at most one
//   result and m_axis_tready stays high; results leave one at a time, and the
//   rate is set by the single read port of the four-entry result queue.
// Reset: clears the parser flags, the token and character counters and the
//   result queue; s_axis_tready is high while the queue is empty, so requests
//   are taken as soon as reset is released.
// Stall: while the receiver holds m_axis_tready low, results wait in the
//   queue; s_axis_tready drops once fewer than two free entries remain.
// ----------------------------------------------------------------------------
module shell_quote_tokenizer_top #(
  parameter int unsigned MAX_TOKENS    = 16,
  parameter int unsigned MAX_TOKEN_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_line
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [8] has_char, [9] token_end,
                                      // [13:10] token_number, [16:14] status,
                                      // [17] line_done, [23:18] zero
  output logic        m_axis_tlast    // last
);

  localparam int unsigned TW = $clog2(MAX_TOKENS + 1);
  localparam int unsigned CW = $clog2(MAX_TOKEN_LEN);

  // Parser state
  sqt_pkg::flags_t flags_q, flags_d;
  logic [TW-1:0]   tokens_q, tokens_d;
  logic [CW-1:0]   chars_q, chars_d;

  sqt_pkg::res_t   res0, res1, head;
  logic [1:0]      res_cnt;
  logic            in_acc;
  logic            room2;
  logic [sqt_pkg::FIFO_CW-1:0] fifo_count;

  assign s_axis_tready = room2;
  assign in_acc        = s_axis_tvalid && room2;

  sqt_step #(
    .MAX_TOKENS    (MAX_TOKENS),
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
    .TW            (TW),
    .CW            (CW)
  ) u_step (
    .in_char_i (s_axis_tdata),
    .eol_i     (s_axis_tlast),
    .flags_i   (flags_q),
    .tokens_i  (tokens_q),
    .chars_i   (chars_q),
    .flags_o   (flags_d),
    .tokens_o  (tokens_d),
    .chars_o   (chars_d),
    .res0_o    (res0),
    .res1_o    (res1),
    .res_cnt_o (res_cnt)
  );

  // State advances only on an accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      tokens_q <= '0;
      chars_q  <= '0;
    end else if (in_acc) begin
      flags_q  <= flags_d;
      tokens_q <= tokens_d;
      chars_q  <= chars_d;
    end
  end

  // Results of an accepted request enter the queue together
  sqt_res_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (in_acc ? res_cnt : 2'd0),
    .push0_i    (res0),
    .push1_i    (res1),
    .room2_o    (room2),
    .valid_o    (m_axis_tvalid),
    .pop_i      (m_axis_tready),
    .data_o     (head),
    .count_o    (fifo_count)
  );

  assign m_axis_tdata = {6'b0, head.line_done, head.status, head.token_number,
                         head.token_end, head.has_char, head.out_char};
  assign m_axis_tlast = head.last;

`ifndef SYNTH
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= sqt_pkg::FIFO_CW'(sqt_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  a_chars_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chars_q <= CW'(MAX_TOKEN_LEN - 1))
    else $error("token character count beyond limit");

  a_tokens_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokens_q <= TW'(MAX_TOKENS))
    else $error("token count beyond limit");

  a_quote_in_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q.inside_quote |-> flags_q.inside_token)
    else $error("open quote outside a token");

  a_eol_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tlast) |=> (flags_q == '0 && tokens_q == '0 && chars_q == '0))
    else $error("state not flushed after end of line");
`endif

endmodule
